// File: sv/pfba_pkg.sv
package pfba_pkg;

   // bitmap geometry
   localparam int BITMAP_BYTES = 4096;
   localparam int IDX_W        = $clog2(BITMAP_BYTES);
   localparam int PTR_W        = $clog2(BITMAP_BYTES + 1);
   localparam int ADDR_IDX_W   = 17;
   localparam int FRAME_SHIFT  = 12;
   localparam logic [7:0] BYTE_FULL = 8'hFF;

   // operation codes
   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_MARK  = 2'd1;
   localparam logic [1:0] OP_TEST  = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   // status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_RANGE = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] address;
   } req_type;

   typedef struct packed {
      logic [31:0] frame_address;
      logic        in_use;
      logic [1:0]  status;
   } rsp_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_ACC
   } state_type;

   typedef enum logic [1:0] {
      PTR_HOLD,
      PTR_START,
      PTR_NEXT
   } ptr_sel_type;

   typedef enum logic [1:0] {
      RES_NONE,
      RES_FOUND,
      RES_ACC
   } res_sel_type;

   typedef struct packed {
      logic        clr_en;
      logic        load;
      ptr_sel_type ptr_sel;
      logic        rsp_load;
      res_sel_type res_sel;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic is_alloc;
      logic is_access;
      logic in_range;
      logic hint_full;
      logic byte_full;
      logic scan_last;
      logic out_free;
   } stat_type;

endpackage

// File: sv/pfba_ram.sv
module pfba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/pfba_ctrl.sv
module pfba_ctrl import pfba_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (stat.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (stat.is_alloc) begin
               if (!stat.hint_full) begin
                  state_in = S_SCAN;
               end else if (stat.out_free) begin
                  state_in = S_IDLE;
               end
            end else if (stat.is_access && stat.in_range) begin
               state_in = S_ACC;
            end else if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if ((!stat.byte_full || stat.scan_last) && stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         S_ACC: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      req_ready    = 1'b0;
      cmd.clr_en   = 1'b0;
      cmd.load     = 1'b0;
      cmd.ptr_sel  = PTR_HOLD;
      cmd.rsp_load = 1'b0;
      cmd.res_sel  = RES_NONE;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_en = 1'b1;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         S_DECODE: begin
            if (stat.is_alloc && !stat.hint_full) begin
               cmd.ptr_sel = PTR_START;
            end else if (stat.is_access && stat.in_range) begin
               cmd.ptr_sel = PTR_START;
            end else begin
               cmd.rsp_load = stat.out_free;
               cmd.res_sel  = RES_NONE;
            end
         end
         S_SCAN: begin
            if (!stat.byte_full) begin
               cmd.rsp_load = stat.out_free;
               cmd.res_sel  = RES_FOUND;
            end else if (stat.scan_last) begin
               cmd.rsp_load = stat.out_free;
               cmd.res_sel  = RES_NONE;
            end else begin
               cmd.ptr_sel = PTR_NEXT;
            end
         end
         S_ACC: begin
            cmd.rsp_load = stat.out_free;
            cmd.res_sel  = RES_ACC;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// File: sv/pfba_datapath.sv
module pfba_datapath import pfba_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cmd_type  cmd,
   output stat_type stat,
   input  req_type  req_data,
   input  logic     rsp_ready,
   output logic     rsp_valid,
   output rsp_type  rsp_data
);

   logic [1:0]       op_ff;
   logic [31:0]      addr_ff;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [PTR_W-1:0] hint_ff, hint_in;
   logic [IDX_W-1:0] clr_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic [ADDR_IDX_W-1:0] byte_idx;
   logic [2:0]            addr_bit;
   logic [2:0]            free_bit;
   logic [7:0]            rd_data;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [7:0]            wr_data;
   logic [2:0]            set_bit;

   // lowest clear bit of a bitmap byte
   function automatic logic [2:0] first_clear(input logic [7:0] value);
      logic [2:0] pos;
      logic       hit;
      pos = 3'd0;
      hit = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (!hit && !value[i]) begin
            pos = 3'(i);
            hit = 1'b1;
         end
      end
      return pos;
   endfunction

   assign byte_idx = addr_ff[31:FRAME_SHIFT+3];
   assign addr_bit = addr_ff[FRAME_SHIFT+2:FRAME_SHIFT];
   assign free_bit = first_clear(rd_data);

   // status to the controller
   assign stat.clr_done  = (clr_ff == IDX_W'(BITMAP_BYTES - 1));
   assign stat.is_alloc  = (op_ff == OP_ALLOC);
   assign stat.is_access = (op_ff == OP_MARK) || (op_ff == OP_TEST);
   assign stat.in_range  = (byte_idx < ADDR_IDX_W'(BITMAP_BYTES));
   assign stat.hint_full = (hint_ff == PTR_W'(BITMAP_BYTES));
   assign stat.byte_full = (rd_data == BYTE_FULL);
   assign stat.scan_last = (ptr_ff == PTR_W'(BITMAP_BYTES - 1));
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   // latch the accepted item
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_data.op;
         addr_ff <= req_data.address;
      end
   end

   // byte pointer: scan position or accessed byte
   always_comb begin
      case (cmd.ptr_sel)
         PTR_START: ptr_in = stat.is_alloc ? hint_ff : PTR_W'(byte_idx);
         PTR_NEXT:  ptr_in = ptr_ff + PTR_W'(1);
         default:   ptr_in = ptr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
   end

   // scan start: every byte from 1 below it is full
   always_comb begin
      hint_in = hint_ff;
      if (cmd.rsp_load && cmd.res_sel == RES_FOUND) begin
         hint_in = ptr_ff;
      end else if (cmd.rsp_load && cmd.res_sel == RES_NONE && stat.is_alloc) begin
         hint_in = PTR_W'(BITMAP_BYTES);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hint_ff <= PTR_W'(1);
         clr_ff  <= '0;
      end else begin
         hint_ff <= hint_in;
         if (cmd.clr_en) clr_ff <= clr_ff + IDX_W'(1);
      end
   end

   // bitmap write: clearing pass or bit set
   assign set_bit = (cmd.res_sel == RES_FOUND) ? free_bit : addr_bit;
   assign wr_en   = cmd.clr_en ||
                    (cmd.rsp_load && (cmd.res_sel == RES_FOUND ||
                                      (cmd.res_sel == RES_ACC && op_ff == OP_MARK)));
   assign wr_addr = cmd.clr_en ? clr_ff : ptr_ff[IDX_W-1:0];
   assign wr_data = cmd.clr_en ? 8'h00 : (rd_data | (8'h01 << set_bit));

   pfba_ram #(
      .WIDTH (8),
      .DEPTH (BITMAP_BYTES)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (ptr_in[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // result value
   always_comb begin
      rsp_data_in = '0;
      case (cmd.res_sel)
         RES_FOUND: begin
            rsp_data_in.frame_address = 32'({ptr_ff[IDX_W-1:0], free_bit,
                                             FRAME_SHIFT'(0)});
            rsp_data_in.status        = STAT_OK;
         end
         RES_ACC: begin
            rsp_data_in.in_use = (op_ff == OP_TEST) && rd_data[addr_bit];
            rsp_data_in.status = STAT_OK;
         end
         default: begin
            if (op_ff == OP_ALLOC) begin
               rsp_data_in.status = STAT_FULL;
            end else if (op_ff == OP_NONE) begin
               rsp_data_in.status = STAT_OK;
            end else begin
               rsp_data_in.status = STAT_RANGE;
            end
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // scan start stays within byte 1 to the end of the bitmap
   a_hint_bounds: assert property (@(posedge clock) disable iff (reset)
      hint_ff >= PTR_W'(1) && hint_ff <= PTR_W'(BITMAP_BYTES))
      else $error("scan start out of bounds");

   // a new result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten");

   // an allocated frame is never one of the first eight
   a_alloc_frame: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_load && cmd.res_sel == RES_FOUND) |=>
         (rsp_data_ff.frame_address[31:FRAME_SHIFT+3] != '0 &&
          rsp_data_ff.status == STAT_OK))
      else $error("bad allocated frame");

   // clearing pass and result never write the bitmap together
   a_clear_excl: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_en |-> !cmd.rsp_load && !cmd.load)
      else $error("activity during clearing pass");

endmodule

// File: sv/page_frame_bitmap_allocator_top.sv
// Physical frame allocator over a bitmap of BITMAP_BYTES bytes, one bit per 4 KiB
// frame. After reset the block clears the bitmap one byte a cycle and takes no item
// until that pass ends. Mark and test go through decode, bitmap read and check before
// the result; an address beyond the bitmap is answered from decode. Allocate scans the
// bitmap byte by byte on the single bitmap read port, past full bytes; the scan
// resumes at the byte where the last allocation landed, so over the block's life
// each full byte is passed over by the scan at most once. A full bitmap is answered
// from decode without a scan. A finished result sits in an output register, and the
// next item is accepted while it waits.
module page_frame_bitmap_allocator_top import pfba_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   pfba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pfba_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
